>>> hw/rtl/pfc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfc_pkg
// shared constants and types of the pixel format converter
// ----------------------------------------------------------------------------
package pfc_pkg;

    localparam int FMT_W     = 3;
    localparam int CFG_IDX_W = 1;
    localparam int PAL_IDX_W = 8;
    localparam int CH_W      = 8;
    localparam int PIX_W     = 32;
    localparam int RGB_W     = 3 * CH_W;
    localparam int S_DATA_W  = PAL_IDX_W + RGB_W + PIX_W;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_IN_FORMAT  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_FORMAT = 1'b1;

    // input depth codes
    localparam logic [FMT_W-1:0] IN_FMT_1BIT    = 3'd0;
    localparam logic [FMT_W-1:0] IN_FMT_PALETTE = 3'd1;
    localparam logic [FMT_W-1:0] IN_FMT_15BIT   = 3'd2;
    localparam logic [FMT_W-1:0] IN_FMT_16BIT   = 3'd3;
    localparam logic [FMT_W-1:0] IN_FMT_24BIT   = 3'd4;
    localparam logic [FMT_W-1:0] IN_FMT_32BIT   = 3'd5;

    // output depth codes
    localparam logic [FMT_W-1:0] OUT_FMT_1BIT  = 3'd0;
    localparam logic [FMT_W-1:0] OUT_FMT_15BIT = 3'd1;
    localparam logic [FMT_W-1:0] OUT_FMT_16BIT = 3'd2;
    localparam logic [FMT_W-1:0] OUT_FMT_24BIT = 3'd3;
    localparam logic [FMT_W-1:0] OUT_FMT_32BIT = 3'd4;

    localparam logic [CH_W-1:0] CH_FULL = 8'hff;

    // palette entry, red in the top byte
    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } rgb_t;

    // pixel request after the input stage
    typedef struct packed {
        logic [PIX_W-1:0] colour;
        logic [FMT_W-1:0] in_fmt;
        logic [FMT_W-1:0] out_fmt;
    } s1_t;

    typedef struct packed {
        logic [CH_W-1:0] alpha;
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } rgba_t;

    // pixel request after unpacking
    typedef struct packed {
        rgba_t            px;
        logic [FMT_W-1:0] out_fmt;
    } s2_t;

endpackage

>>> hw/rtl/pfc_palette.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfc_palette
// palette memory with per-entry valid bits and registered read
// ----------------------------------------------------------------------------
module pfc_palette #(
    parameter int PALETTE_ENTRIES = 256
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          wr_en,
    input  logic [pfc_pkg::PAL_IDX_W-1:0] wr_idx,
    input  pfc_pkg::rgb_t                 wr_rgb,
    input  logic                          rd_en,
    input  logic [pfc_pkg::PAL_IDX_W-1:0] rd_idx,
    output pfc_pkg::rgb_t                 rd_rgb
);
    import pfc_pkg::*;

    localparam int IDX_W = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
    localparam logic [PAL_IDX_W:0] ENTRIES = (PAL_IDX_W + 1)'(PALETTE_ENTRIES);

    rgb_t                       mem [PALETTE_ENTRIES];
    logic [PALETTE_ENTRIES-1:0] valid_reg;
    rgb_t                       rd_mem_reg;
    logic                       rd_hit_reg;

    logic             wr_hit;
    logic             rd_in_range;
    logic [IDX_W-1:0] wr_addr;
    logic [IDX_W-1:0] rd_addr;

    assign wr_addr     = wr_idx[IDX_W-1:0];
    assign rd_addr     = rd_idx[IDX_W-1:0];
    assign wr_hit      = wr_en && ({1'b0, wr_idx} < ENTRIES);
    assign rd_in_range = {1'b0, rd_idx} < ENTRIES;

    always_ff @(posedge aclk) begin
        if (wr_hit) begin
            mem[wr_addr] <= wr_rgb;
        end
        if (rd_en) begin
            rd_mem_reg <= mem[rd_addr];
        end
    end

    // entries never written read as black
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg  <= '0;
            rd_hit_reg <= 1'b0;
        end else begin
            if (wr_hit) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                rd_hit_reg <= rd_in_range && valid_reg[rd_addr];
            end
        end
    end

    assign rd_rgb = rd_hit_reg ? rd_mem_reg : '0;

endmodule

>>> hw/rtl/pfc_unpack.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfc_unpack
// splits a source pixel into 8-bit channels and alpha
// ----------------------------------------------------------------------------
module pfc_unpack (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           valid_in,
    input  pfc_pkg::s1_t   data_in,
    input  pfc_pkg::rgb_t  pal_rgb,
    output logic           ready_out,
    output logic           valid_out,
    output pfc_pkg::s2_t   data_out,
    input  logic           ready_in
);
    import pfc_pkg::*;

    logic  valid_reg;
    s2_t   data_reg;
    rgba_t px_next;
    logic [PIX_W-1:0] c;

    assign c         = data_in.colour;
    assign ready_out = !valid_reg || ready_in;

    // for 15- and 16-bit sources, low bits filled by replicating the top bits of each field
    always_comb begin
        px_next = '{alpha: CH_FULL, red: '0, green: '0, blue: '0};
        case (data_in.in_fmt)
            IN_FMT_1BIT: begin
                if (c != '0) begin
                    px_next.red   = CH_FULL;
                    px_next.green = CH_FULL;
                    px_next.blue  = CH_FULL;
                end
            end
            IN_FMT_PALETTE: begin
                px_next.red   = pal_rgb.red;
                px_next.green = pal_rgb.green;
                px_next.blue  = pal_rgb.blue;
            end
            IN_FMT_15BIT: begin
                px_next.red   = {c[14:10], c[14:12]};
                px_next.green = {c[9:5], c[9:7]};
                px_next.blue  = {c[4:0], c[4:2]};
            end
            IN_FMT_16BIT: begin
                px_next.red   = {c[15:11], c[15:13]};
                px_next.green = {c[10:5], c[10:9]};
                px_next.blue  = {c[4:0], c[4:2]};
            end
            IN_FMT_24BIT: begin
                px_next.red   = c[7:0];
                px_next.green = c[15:8];
                px_next.blue  = c[23:16];
            end
            IN_FMT_32BIT: begin
                px_next.red   = c[7:0];
                px_next.green = c[15:8];
                px_next.blue  = c[23:16];
                px_next.alpha = c[31:24];
            end
            default: begin
                px_next = '{alpha: CH_FULL, red: '0, green: '0, blue: '0};
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (ready_out) begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (ready_out && valid_in) begin
            data_reg.px      <= px_next;
            data_reg.out_fmt <= data_in.out_fmt;
        end
    end

    assign valid_out = valid_reg;
    assign data_out  = data_reg;

endmodule

>>> hw/rtl/pfc_pack.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfc_pack
// packs channels into the output depth and holds the result register
// ----------------------------------------------------------------------------
module pfc_pack (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      valid_in,
    input  pfc_pkg::s2_t              data_in,
    output logic                      ready_out,
    output logic                      m_valid,
    output logic [pfc_pkg::PIX_W-1:0] m_data,
    input  logic                      m_ready
);
    import pfc_pkg::*;

    logic             valid_reg;
    logic [PIX_W-1:0] data_reg;
    logic [PIX_W-1:0] data_next;
    rgba_t            p;

    assign p         = data_in.px;
    assign ready_out = !valid_reg || m_ready;

    always_comb begin
        case (data_in.out_fmt)
            OUT_FMT_1BIT: begin
                data_next = {{(PIX_W - 1){1'b0}}, |{p.red, p.green, p.blue}};
            end
            OUT_FMT_15BIT: begin
                data_next = {17'd0, p.red[7:3], p.green[7:3], p.blue[7:3]};
            end
            OUT_FMT_16BIT: begin
                data_next = {16'd0, p.red[7:3], p.green[7:2], p.blue[7:3]};
            end
            OUT_FMT_24BIT: begin
                data_next = {8'd0, p.red, p.green, p.blue};
            end
            OUT_FMT_32BIT: begin
                data_next = {p.alpha, p.red, p.green, p.blue};
            end
            default: begin
                data_next = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (ready_out) begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (ready_out && valid_in) begin
            data_reg <= data_next;
        end
    end

    assign m_valid = valid_reg;
    assign m_data  = data_reg;

endmodule

>>> hw/rtl/pixel_format_converter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pixel_format_converter
// converts pixels between colour depths, with a 1/8/15/16/24/32-bit source
// ----------------------------------------------------------------------------
// takes one request per clock when not stalled and, for a pixel request, gives
// one converted pixel through three register stages: input and palette read,
// channel unpack, output pack into the result register. a palette write
// request (tuser low) updates the palette entry at once and gives no result; a
// pixel request right behind it already sees the new entry. the palette comes
// out of reset all black through per-entry valid bits, so no clearing pass is
// needed and requests are taken from the first cycle after reset. each stage
// stalls only when it is full and the stage after it is stalled, so bubbles
// close up and the input keeps flowing while a result waits. the user must
// write in_format and out_format through the cfg port only while the block
// holds no request, unenforced; each pixel carries its own copy down the pipe.
// ----------------------------------------------------------------------------
module pixel_format_converter #(
    parameter int PALETTE_ENTRIES = 256
) (
    input  logic                          aclk,
    input  logic                          aresetn,

    input  logic                          cfg_wr_en,
    input  logic [pfc_pkg::CFG_IDX_W-1:0] cfg_wr_addr,
    input  logic [pfc_pkg::FMT_W-1:0]     cfg_wr_data,

    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // palette_index[7:0], palette_red[15:8], palette_green[23:16],
    // palette_blue[31:24], colour_in[63:32]
    input  logic [pfc_pkg::S_DATA_W-1:0]  s_axis_tdata,
    // mode[0]: 0 palette write, 1 pixel convert
    input  logic                          s_axis_tuser,

    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // colour_out[31:0]
    output logic [pfc_pkg::PIX_W-1:0]     m_axis_tdata
);
    import pfc_pkg::*;

    // configuration registers
    logic [FMT_W-1:0] in_fmt_reg;
    logic [FMT_W-1:0] out_fmt_reg;

    // input stage
    logic s1_valid_reg;
    s1_t  s1_data_reg;
    logic s1_ready;
    logic in_accept;

    // request fields
    logic [PAL_IDX_W-1:0] req_idx;
    rgb_t                 req_rgb;
    logic [PIX_W-1:0]     req_colour;

    rgb_t pal_rgb;
    logic s2_ready;
    logic s2_valid;
    s2_t  s2_data;
    logic s3_ready;

    assign req_idx       = s_axis_tdata[PAL_IDX_W-1:0];
    assign req_rgb.red   = s_axis_tdata[PAL_IDX_W +: CH_W];
    assign req_rgb.green = s_axis_tdata[PAL_IDX_W + CH_W +: CH_W];
    assign req_rgb.blue  = s_axis_tdata[PAL_IDX_W + 2 * CH_W +: CH_W];
    assign req_colour    = s_axis_tdata[PAL_IDX_W + RGB_W +: PIX_W];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_fmt_reg  <= IN_FMT_24BIT;
            out_fmt_reg <= OUT_FMT_32BIT;
        end else if (cfg_wr_en) begin
            case (cfg_wr_addr)
                REG_IN_FORMAT:  in_fmt_reg  <= cfg_wr_data;
                REG_OUT_FORMAT: out_fmt_reg <= cfg_wr_data;
                default: begin
                end
            endcase
        end
    end

    // input stage advances when empty or when unpack takes its request
    assign s1_ready      = !s1_valid_reg || s2_ready;
    assign s_axis_tready = s1_ready;
    assign in_accept     = s_axis_tvalid && s1_ready;

    // palette writes end here, only pixel requests move on
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s1_ready) begin
            s1_valid_reg <= in_accept && s_axis_tuser;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept && s_axis_tuser) begin
            s1_data_reg.colour  <= req_colour;
            s1_data_reg.in_fmt  <= in_fmt_reg;
            s1_data_reg.out_fmt <= out_fmt_reg;
        end
    end

    // palette lookup uses the low byte of the pixel, read data lines up
    // with the input stage register
    pfc_palette #(
        .PALETTE_ENTRIES (PALETTE_ENTRIES)
    ) u_palette (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (in_accept && !s_axis_tuser),
        .wr_idx  (req_idx),
        .wr_rgb  (req_rgb),
        .rd_en   (in_accept && s_axis_tuser),
        .rd_idx  (req_colour[PAL_IDX_W-1:0]),
        .rd_rgb  (pal_rgb)
    );

    pfc_unpack u_unpack (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .valid_in  (s1_valid_reg),
        .data_in   (s1_data_reg),
        .pal_rgb   (pal_rgb),
        .ready_out (s2_ready),
        .valid_out (s2_valid),
        .data_out  (s2_data),
        .ready_in  (s3_ready)
    );

    pfc_pack u_pack (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .valid_in  (s2_valid),
        .data_in   (s2_data),
        .ready_out (s3_ready),
        .m_valid   (m_axis_tvalid),
        .m_data    (m_axis_tdata),
        .m_ready   (m_axis_tready)
    );

endmodule

>>> hw/rtl/pfc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfc_checker
// port-level checks of the pixel format converter
// ----------------------------------------------------------------------------
module pfc_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_axis_tvalid,
    input  logic                          s_axis_tready,
    input  logic                          s_axis_tuser,
    input  logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    input  logic [pfc_pkg::PIX_W-1:0]     m_axis_tdata
);
    import pfc_pkg::*;

    logic pixel_accept;

    assign pixel_accept = s_axis_tvalid && s_axis_tready && s_axis_tuser;

    // result leaves reset empty
    assert property (@(posedge aclk) !aresetn |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    // an empty result register never blocks the input
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with no result pending");

    // a pixel request reaches the result register when the output keeps taking results
    assert property (@(posedge aclk) disable iff (!aresetn)
        pixel_accept ##1 m_axis_tready ##1 m_axis_tready |=> m_axis_tvalid)
        else $error("pixel request did not reach the output");

    // a stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

endmodule

bind pixel_format_converter pfc_checker u_pfc_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
